### src/sswm_pkg.sv
// Shared types and constants of the sparse-set engine.
package sswm_pkg;

  // Key universe and derived widths
  localparam int unsigned UNIVERSE = 4096;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned KEY_W    = 12;
  localparam int unsigned CNT_W    = 13;

  // Operation codes
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_MIN  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(UNIVERSE);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(UNIVERSE - 1);

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] min_value;
    logic [CNT_W-1:0] member_count;
    logic             error;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_POP_RD,
    ST_POP_WR,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Requests toward the two memories
  typedef struct packed {
    logic              dense_we;
    logic [ADDR_W-1:0] dense_waddr;
    logic [KEY_W-1:0]  dense_wdata;
    logic [ADDR_W-1:0] dense_raddr;
    logic              pmap_we;
    logic [ADDR_W-1:0] pmap_waddr;
    logic [ADDR_W-1:0] pmap_wdata;
    logic [ADDR_W-1:0] pmap_raddr;
  } mem_req_t;

  // Registered read data of the two memories
  typedef struct packed {
    logic [KEY_W-1:0]  dense_rdata;
    logic [ADDR_W-1:0] pmap_rdata;
  } mem_rsp_t;

endpackage

### src/sswm_store.sv
// Dense key array and position map, each one write and one registered read port.
module sswm_store (
  input  logic             clk,
  input  sswm_pkg::mem_req_t req,
  output sswm_pkg::mem_rsp_t rsp
);

  logic [sswm_pkg::KEY_W-1:0]  dense_mem [sswm_pkg::UNIVERSE];
  logic [sswm_pkg::ADDR_W-1:0] pmap_mem  [sswm_pkg::UNIVERSE];

  // Dense key array and key to dense position map
  always_ff @(posedge clk) begin
    if (req.dense_we) begin
      dense_mem[req.dense_waddr] <= req.dense_wdata;
    end
    if (req.pmap_we) begin
      pmap_mem[req.pmap_waddr] <= req.pmap_wdata;
    end
    rsp.dense_rdata <= dense_mem[req.dense_raddr];
    rsp.pmap_rdata  <= pmap_mem[req.pmap_raddr];
  end

endmodule

### src/sswm_seq.sv
// Operation sequencer: member count, swap-remove steps, minimum scan, result register.
module sswm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sswm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sswm_pkg::out_item_t out_data,
  output sswm_pkg::mem_req_t  req,
  input  sswm_pkg::mem_rsp_t  rsp
);

  sswm_pkg::state_t state_r, state_nxt;

  logic [sswm_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [sswm_pkg::ADDR_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [sswm_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [sswm_pkg::CNT_W-1:0]  best_r, best_nxt;
  logic                        err_r, err_nxt;
  logic [sswm_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic                        out_valid_r, out_valid_nxt;
  sswm_pkg::out_item_t         out_data_r, out_data_nxt;

  logic in_acc;
  logic out_free;
  logic scan_issue;
  logic [sswm_pkg::CNT_W-1:0] last_idx;

  assign in_stall   = (state_r != sswm_pkg::ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign scan_issue = (idx_r < count_r);
  assign last_idx   = count_r - sswm_pkg::CNT_W'(1);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sswm_pkg::ST_CLEAR: begin
        if (clr_idx_r == sswm_pkg::ADDR_LAST) begin
          state_nxt = sswm_pkg::ST_IDLE;
        end
      end
      sswm_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.mode)
            sswm_pkg::MODE_PUSH: state_nxt = sswm_pkg::ST_PUSH;
            sswm_pkg::MODE_POP:  state_nxt = sswm_pkg::ST_POP_RD;
            sswm_pkg::MODE_MIN:  state_nxt = sswm_pkg::ST_SCAN;
            default:             state_nxt = sswm_pkg::ST_DONE;
          endcase
        end
      end
      sswm_pkg::ST_PUSH: state_nxt = sswm_pkg::ST_DONE;
      sswm_pkg::ST_POP_RD: begin
        state_nxt = (count_r == '0) ? sswm_pkg::ST_DONE : sswm_pkg::ST_POP_WR;
      end
      sswm_pkg::ST_POP_WR: state_nxt = sswm_pkg::ST_DONE;
      sswm_pkg::ST_SCAN: begin
        if (!scan_issue && !rd_vld_r) begin
          state_nxt = sswm_pkg::ST_DONE;
        end
      end
      sswm_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = sswm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sswm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    count_nxt     = count_r;
    clr_idx_nxt   = clr_idx_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    best_nxt      = best_r;
    err_nxt       = err_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    req             = '0;
    req.pmap_raddr  = key_r;
    req.dense_raddr = last_idx[sswm_pkg::ADDR_W-1:0];

    case (state_r)
      sswm_pkg::ST_CLEAR: begin
        // Position map sweep to its all-zero reset value
        req.pmap_we    = 1'b1;
        req.pmap_waddr = clr_idx_r;
        req.pmap_wdata = '0;
        clr_idx_nxt    = clr_idx_r + sswm_pkg::ADDR_W'(1);
      end
      sswm_pkg::ST_IDLE: begin
        if (in_acc) begin
          key_nxt  = in_data.key;
          err_nxt  = 1'b0;
          idx_nxt  = '0;
          best_nxt = (in_data.mode == sswm_pkg::MODE_MIN) ? sswm_pkg::CNT_FULL : '0;
        end
      end
      sswm_pkg::ST_PUSH: begin
        if (count_r >= sswm_pkg::CNT_FULL) begin
          err_nxt = 1'b1;
        end else begin
          req.pmap_we     = 1'b1;
          req.pmap_waddr  = key_r;
          req.pmap_wdata  = count_r[sswm_pkg::ADDR_W-1:0];
          req.dense_we    = 1'b1;
          req.dense_waddr = count_r[sswm_pkg::ADDR_W-1:0];
          req.dense_wdata = key_r;
          count_nxt       = count_r + sswm_pkg::CNT_W'(1);
        end
      end
      sswm_pkg::ST_POP_RD: begin
        // Reads of the key's slot and the last entry go out here
        if (count_r == '0) begin
          err_nxt = 1'b1;
        end
      end
      sswm_pkg::ST_POP_WR: begin
        // Move last entry into the freed slot and repoint its map slot
        req.dense_we    = 1'b1;
        req.dense_waddr = rsp.pmap_rdata;
        req.dense_wdata = rsp.dense_rdata;
        req.pmap_we     = 1'b1;
        req.pmap_waddr  = rsp.dense_rdata;
        req.pmap_wdata  = rsp.pmap_rdata;
        count_nxt       = last_idx;
      end
      sswm_pkg::ST_SCAN: begin
        // One read issued and one compare per cycle
        req.dense_raddr = idx_r[sswm_pkg::ADDR_W-1:0];
        if (scan_issue) begin
          idx_nxt    = idx_r + sswm_pkg::CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && ({1'b0, rsp.dense_rdata} < best_r)) begin
          best_nxt = {1'b0, rsp.dense_rdata};
        end
      end
      sswm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.min_value    = best_r;
          out_data_nxt.member_count = count_r;
          out_data_nxt.error        = err_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sswm_pkg::ST_CLEAR;
      count_r     <= '0;
      clr_idx_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      clr_idx_r   <= clr_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    err_r      <= err_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  // Count stays within the universe
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sswm_pkg::CNT_FULL)
    else $error("member count beyond universe");

  // Count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + sswm_pkg::CNT_W'(1)
         || count_r == $past(count_r) - sswm_pkg::CNT_W'(1)))
    else $error("member count jumped");

  // Swap-remove write only on a non-empty set
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sswm_pkg::ST_POP_WR |-> count_r != '0)
    else $error("pop write on empty set");

  // A fresh result comes only from the done state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r && out_stall) |-> $past(state_r) == sswm_pkg::ST_DONE)
    else $error("result loaded outside done state");

endmodule

### src/sparse_set_with_min_core.sv
// Top level of the sparse-set engine with minimum query.
// Sparse set over keys 0..4095 held in two single-port-write memories: a dense
// key array and a key-to-position map, plus a member count. After reset the
// block runs a pass that zeroes the position map and holds in_stall high until
// it ends. One item is in work at a time. From acceptance to the result
// register, a push passes its write state; a pop passes a memory read state
// and then the swap-remove write (the write is skipped on an empty set); an
// unused mode goes straight to the done state; and a minimum query runs a scan
// that reads one dense entry per cycle. A new item is taken the cycle after its
// predecessor's result is loaded, even while that result still waits on
// out_stall. Push on a full set and pop on an empty set flag error and change
// nothing; membership is not checked.
module sparse_set_with_min_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sswm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sswm_pkg::out_item_t out_data
);

  sswm_pkg::mem_req_t req;
  sswm_pkg::mem_rsp_t rsp;

  sswm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .req       (req),
    .rsp       (rsp)
  );

  sswm_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

endmodule
